@@ rtl/ecbt_pkg.sv @@
// shared types, constants and codes for the endpoint circuit breaker table
// no dependencies
`default_nettype none

package ecbt_pkg;

  localparam int CMD_W          = 2;
  localparam int EP_W           = 6;
  localparam int IN_TIME_W      = 32;
  localparam int STATUS_W       = 10;
  localparam int OUT_TIME_W     = 32;
  localparam int THR_W          = 8;
  localparam int COOL_W         = 16;
  localparam int COUNT_W        = 8;
  localparam int CFG_DATA_W     = 16;
  localparam int CFG_INDEX_W    = 1;

  localparam int DEF_TABLE_ENTRIES = 64;
  localparam int DEF_TIME_WIDTH    = 32;
  localparam int QUEUE_DEPTH       = 2;

  localparam logic [COUNT_W-1:0]  COUNT_MAX  = 8'd255;
  localparam logic [THR_W-1:0]    THR_RESET  = 8'd5;
  localparam logic [COOL_W-1:0]   COOL_RESET = 16'd30;

  localparam logic [STATUS_W-1:0] STATUS_UNKNOWN    = 10'd0;
  localparam logic [STATUS_W-1:0] STATUS_RATE_LIMIT = 10'd429;
  localparam logic [STATUS_W-1:0] STATUS_SERVER_LO  = 10'd500;
  localparam logic [STATUS_W-1:0] STATUS_SERVER_HI  = 10'd599;

  localparam logic [CFG_INDEX_W-1:0] REG_TRIP_LIMIT      = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_COOLOFF_SECONDS = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOW   = 2'd0,
    CMD_SUCCESS = 2'd1,
    CMD_FAILURE = 2'd2,
    CMD_QUERY   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_CLOSED = 2'd0,
    ST_OPEN   = 2'd1,
    ST_HALF   = 2'd2
  } brk_state_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_EXEC
  } bk_state_t;

  typedef struct packed {
    logic [CMD_W-1:0]     command;
    logic [EP_W-1:0]      endpoint_index;
    logic [IN_TIME_W-1:0] now_time;
    logic [STATUS_W-1:0]  resp_code;
  } req_t;

  typedef struct packed {
    logic                  allowed;
    logic [1:0]            breaker_state;
    logic [OUT_TIME_W-1:0] open_until_time;
    logic                  failure_ignored;
  } rsp_t;

  typedef struct packed {
    logic [THR_W-1:0]  trip_limit;
    logic [COOL_W-1:0] cooloff_seconds;
  } cfg_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } back_status_t;

  typedef struct packed {
    brk_state_t         st;
    logic [COUNT_W-1:0] fail_count;
    logic               probe;
  } entry_ctl_t;

endpackage

`default_nettype wire

@@ rtl/ecbt_queue.sv @@
// short word queue between the front and the back
// uses ecbt_pkg for nothing; depth and width come from parameters
`default_nettype none

module ecbt_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] data_in,
  output logic                  full,
  input  wire logic             pop,
  output logic                  empty,
  output logic [WIDTH-1:0]      head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == FULL_COUNT);
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= data_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/ecbt_front.sv @@
// request intake: index folding, time cut, status classification, queue push
// depends on ecbt_pkg
`default_nettype none

module ecbt_front #(
  parameter int TABLE_ENTRIES = ecbt_pkg::DEF_TABLE_ENTRIES,
  parameter int TIME_WIDTH    = ecbt_pkg::DEF_TIME_WIDTH,
  parameter int QW            = 2 + 1 + $clog2(TABLE_ENTRIES) + TIME_WIDTH
) (
  input  wire logic                  req_valid,
  output logic                       req_stall,
  input  wire ecbt_pkg::req_t        req,
  input  wire ecbt_pkg::back_status_t status,
  output logic                       q_push,
  output logic [QW-1:0]              q_data,
  input  wire logic                  q_full
);

  import ecbt_pkg::*;

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int EP_NUM = 1 << EP_W;

  logic [IDX_W-1:0] idx_map [EP_NUM];
  logic             counted;
  logic [TIME_WIDTH-1:0] now_cut;

  for (genvar v = 0; v < EP_NUM; v++) begin : g_idx
    assign idx_map[v] = IDX_W'(v % TABLE_ENTRIES);
  end

  always_comb begin
    counted = (req.resp_code == STATUS_UNKNOWN)
           || (req.resp_code == STATUS_RATE_LIMIT)
           || ((req.resp_code >= STATUS_SERVER_LO)
               && (req.resp_code <= STATUS_SERVER_HI));
  end

  assign now_cut   = TIME_WIDTH'(req.now_time);
  assign req_stall = q_full | status.clearing;
  assign q_push    = req_valid & ~req_stall;
  assign q_data    = {req.command, counted, idx_map[req.endpoint_index], now_cut};

endmodule

`default_nettype wire

@@ rtl/ecbt_back.sv @@
// breaker table and its read-modify-write sequencer, result register
// depends on ecbt_pkg; table cleared by a sweep after reset
`default_nettype none

module ecbt_back #(
  parameter int TABLE_ENTRIES = ecbt_pkg::DEF_TABLE_ENTRIES,
  parameter int TIME_WIDTH    = ecbt_pkg::DEF_TIME_WIDTH,
  parameter int QW            = 2 + 1 + $clog2(TABLE_ENTRIES) + TIME_WIDTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire ecbt_pkg::cfg_t         cfg,
  input  wire logic                   q_empty,
  input  wire logic [QW-1:0]          q_head,
  output logic                        q_pop,
  output ecbt_pkg::back_status_t      status,
  output logic                        rsp_valid,
  input  wire logic                   rsp_stall,
  output ecbt_pkg::rsp_t              rsp
);

  import ecbt_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CTL_W = $bits(entry_ctl_t);
  localparam int ENT_W = CTL_W + TIME_WIDTH;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  logic [ENT_W-1:0] table_mem [TABLE_ENTRIES];
  logic [ENT_W-1:0] rd_data;

  bk_state_t state;
  bk_state_t state_next;
  logic [IDX_W-1:0] clr_idx;

  cmd_t                  w_cmd;
  logic                  w_counted;
  logic [IDX_W-1:0]      w_idx;
  logic [TIME_WIDTH-1:0] w_now;

  logic                  mem_we;
  logic                  mem_re;
  logic [IDX_W-1:0]      mem_addr;
  logic [ENT_W-1:0]      mem_wdata;
  logic                  out_free;
  logic                  load_out;

  entry_ctl_t            cur_ctl;
  logic [TIME_WIDTH-1:0] cur_dl;
  entry_ctl_t            new_ctl;
  logic [TIME_WIDTH-1:0] new_dl;
  logic [TIME_WIDTH:0]   dl_sum;
  logic [TIME_WIDTH-1:0] dl_trip;
  logic [COUNT_W-1:0]    cnt_inc;
  logic                  expire;
  logic                  trip;
  rsp_t                  rsp_next;

  assign out_free = ~rsp_valid | ~rsp_stall;
  assign cur_ctl  = entry_ctl_t'(rd_data[ENT_W-1 -: CTL_W]);
  assign cur_dl   = rd_data[TIME_WIDTH-1:0];
  assign status.clearing = (state == BK_CLEAR);
  assign status.busy     = (state == BK_EXEC);

  // table: one port, read data registered
  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= table_mem[mem_addr];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BK_CLEAR: if (clr_idx == LAST_IDX) state_next = BK_IDLE;
      BK_IDLE:  if (!q_empty) state_next = BK_EXEC;
      BK_EXEC:  if (out_free) state_next = BK_IDLE;
      default:  state_next = BK_CLEAR;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    load_out  = 1'b0;
    mem_addr  = w_idx;
    mem_wdata = {new_ctl, new_dl};
    unique case (state)
      BK_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_idx;
        mem_wdata = '0;
      end
      BK_IDLE: begin
        q_pop    = ~q_empty;
        mem_re   = ~q_empty;
        mem_addr = q_head[TIME_WIDTH +: IDX_W];
      end
      BK_EXEC: begin
        mem_we   = out_free;
        load_out = out_free;
      end
      default: ;
    endcase
  end

  // entry update
  always_comb begin
    dl_sum  = {1'b0, w_now} + (TIME_WIDTH + 1)'(cfg.cooloff_seconds);
    dl_trip = dl_sum[TIME_WIDTH] ? '1 : dl_sum[TIME_WIDTH-1:0];
    cnt_inc = (cur_ctl.fail_count < COUNT_MAX) ? cur_ctl.fail_count + 1'b1
                                               : cur_ctl.fail_count;
    expire  = (cur_ctl.st == ST_OPEN) && (w_now >= cur_dl)
           && ((w_cmd != CMD_SUCCESS) && ((w_cmd != CMD_FAILURE) || w_counted));
    new_ctl = cur_ctl;
    new_dl  = cur_dl;
    trip    = 1'b0;
    rsp_next = '0;
    if (expire) begin
      new_ctl.st    = ST_HALF;
      new_ctl.probe = 1'b0;
    end
    case (w_cmd)
      CMD_ALLOW: begin
        if (new_ctl.st == ST_CLOSED) begin
          rsp_next.allowed = 1'b1;
        end else if (new_ctl.st == ST_HALF && !new_ctl.probe) begin
          rsp_next.allowed = 1'b1;
          new_ctl.probe    = 1'b1;
        end
      end
      CMD_SUCCESS: begin
        new_ctl = '{st: ST_CLOSED, fail_count: '0, probe: 1'b0};
        new_dl  = '0;
      end
      CMD_FAILURE: begin
        if (!w_counted) begin
          rsp_next.failure_ignored = 1'b1;
        end else if (new_ctl.st == ST_HALF) begin
          trip = 1'b1;
        end else if (new_ctl.st == ST_CLOSED) begin
          new_ctl.fail_count = cnt_inc;
          trip = (cnt_inc >= cfg.trip_limit);
        end
      end
      default: ;
    endcase
    if (trip) begin
      new_ctl.st    = ST_OPEN;
      new_ctl.probe = 1'b0;
      new_dl        = dl_trip;
    end
    rsp_next.breaker_state   = new_ctl.st;
    rsp_next.open_until_time = (new_ctl.st == ST_OPEN) ? OUT_TIME_W'(new_dl) : '0;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      w_cmd     <= cmd_t'(q_head[QW-1 -: CMD_W]);
      w_counted <= q_head[TIME_WIDTH + IDX_W];
      w_idx     <= q_head[TIME_WIDTH +: IDX_W];
      w_now     <= q_head[TIME_WIDTH-1:0];
    end
    if (load_out) begin
      rsp <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_CLEAR;
      clr_idx   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == BK_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (load_out) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/endpoint_circuit_breaker_table.sv @@
// endpoint circuit breaker table, top level: config registers, front, queue, back
// request path: queue slot, table read and word registers, result register
// one word in the back at a time: read then write of the single-port table
// reset: sweeps every entry to closed, one entry a cycle, requests stalled
// depends on ecbt_pkg, ecbt_front, ecbt_queue, ecbt_back
`default_nettype none

module endpoint_circuit_breaker_table #(
  parameter int TABLE_ENTRIES = ecbt_pkg::DEF_TABLE_ENTRIES,
  parameter int TIME_WIDTH    = ecbt_pkg::DEF_TIME_WIDTH
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  req_valid,
  output logic                                       req_stall,
  input  wire ecbt_pkg::req_t                        req,
  output logic                                       rsp_valid,
  input  wire logic                                  rsp_stall,
  output ecbt_pkg::rsp_t                             rsp,
  input  wire logic                                  cfg_we,
  input  wire logic [ecbt_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic [ecbt_pkg::CFG_DATA_W-1:0]       cfg_data
);

  import ecbt_pkg::*;

  localparam int QW = 2 + 1 + $clog2(TABLE_ENTRIES) + TIME_WIDTH;

  cfg_t         cfg;
  back_status_t status;
  logic         q_push;
  logic         q_pop;
  logic         q_full;
  logic         q_empty;
  logic [QW-1:0] q_data;
  logic [QW-1:0] q_head;

  // a zero threshold write is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trip_limit      <= THR_RESET;
      cfg.cooloff_seconds <= COOL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TRIP_LIMIT: begin
          if (cfg_data[THR_W-1:0] != '0) begin
            cfg.trip_limit <= cfg_data[THR_W-1:0];
          end
        end
        REG_COOLOFF_SECONDS: cfg.cooloff_seconds <= cfg_data[COOL_W-1:0];
        default: ;
      endcase
    end
  end

  ecbt_front #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .TIME_WIDTH    (TIME_WIDTH),
    .QW            (QW)
  ) u_front (
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .status    (status),
    .q_push    (q_push),
    .q_data    (q_data),
    .q_full    (q_full)
  );

  ecbt_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .data_in (q_data),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .head    (q_head)
  );

  ecbt_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .TIME_WIDTH    (TIME_WIDTH),
    .QW            (QW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .status    (status),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  a_no_accept_while_clearing : assert property (
    @(posedge clk) disable iff (rst) status.clearing |-> req_stall
  ) else $error("request taken during table sweep");

  a_threshold_nonzero : assert property (
    @(posedge clk) disable iff (rst) cfg.trip_limit != '0
  ) else $error("failure threshold is zero");

  a_deadline_only_when_open : assert property (
    @(posedge clk) disable iff (rst)
      rsp_valid && (rsp.breaker_state != ST_OPEN) |-> rsp.open_until_time == '0
  ) else $error("deadline shown for an entry that is not open");

  a_open_never_allows : assert property (
    @(posedge clk) disable iff (rst)
      rsp_valid && rsp.allowed |-> rsp.breaker_state != ST_OPEN
  ) else $error("request allowed through an open breaker");

  a_pop_only_when_idle : assert property (
    @(posedge clk) disable iff (rst) q_pop |-> !status.busy && !q_empty
  ) else $error("queue popped while an entry update is pending");

endmodule

`default_nettype wire
